// ===== hdl/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
// Command and status bundles that join the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

  localparam int GRANULE_SHIFT = 4;
  localparam int NEED_W        = 13;
  localparam int HB_W          = 17;
  localparam logic [HB_W-1:0] HEAP_BYTES_RESET = 17'h10000;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_ZERO_SIZE   = 3'd1,
    ST_NO_FIT      = 3'd2,
    ST_NULL_FREE   = 3'd3,
    ST_BAD_ADDR    = 3'd4,
    ST_DOUBLE_FREE = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_CLR_STEP,
    CMD_LOAD,
    CMD_WALK_START,
    CMD_WALK_STEP,
    CMD_A_TAKE,
    CMD_A_SPLIT,
    CMD_F_READ,
    CMD_F_TAKE,
    CMD_F_MERGE_NEXT,
    CMD_F_CLR_NEXT,
    CMD_F_MERGE_PREV,
    CMD_F_CLR_U,
    CMD_RESULT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    status_t st;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free_op;
    logic req_zero;
    logic walk_end;
    logic fit;
    logic split;
    logic off_null;
    logic off_bad;
    logic blk_absent;
    logic blk_free;
    logic next_merge;
    logic at_target;
    logic target_zero;
    logic prev_free;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/ffha_dp.sv =====
// Datapath of the first-fit heap allocator: block table memory, walk
// registers, payload totals, configuration register and result register.
// Depends on ffha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffha_dp
  import ffha_pkg::*;
#(
  parameter int HEAP_UNITS   = 4096,
  parameter int HEADER_BYTES = 24,
  parameter int MIN_BLOCK    = 40
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire dp_cmd_t         cmd,
  output dp_stat_t             stat,
  input  wire logic            in_opcode,
  input  wire logic [15:0]     in_request_bytes,
  input  wire logic [15:0]     in_payload_offset,
  input  wire logic            cfg_wr,
  input  wire logic [HB_W-1:0] cfg_wdata,
  output logic [HB_W-1:0]      heap_bytes,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [2:0]           out_status,
  output logic [15:0]          out_result_offset,
  output logic [15:0]          out_free_payload_bytes,
  output logic [15:0]          out_used_payload_bytes
);

  localparam int AW    = (HEAP_UNITS > 1) ? $clog2(HEAP_UNITS) : 1;
  localparam int LW    = AW + 1;
  localparam int MINU  = (MIN_BLOCK + 15) / 16;
  localparam int HDRU  = (HEADER_BYTES + 15) / 16 + 1;
  localparam int FL0   = (HDRU > 3) ? HDRU : 3;
  localparam int FL1   = (MINU > FL0) ? MINU : FL0;
  localparam int FLOOR = (FL1 > HEAP_UNITS) ? HEAP_UNITS : FL1;

  function automatic logic [LW-1:0] units_of(input logic [HB_W-1:0] hb);
    int s;
    s = int'(hb[HB_W-1:GRANULE_SHIFT]);
    if (s > HEAP_UNITS) s = HEAP_UNITS;
    if (s < FLOOR) s = FLOOR;
    return LW'(s);
  endfunction

  function automatic logic [15:0] bytes_of(input logic [LW-1:0] n);
    logic [31:0] t;
    t = 32'(n) << GRANULE_SHIFT;
    return t[15:0];
  endfunction

  function automatic logic [15:0] pay(input logic [LW-1:0] n);
    logic [31:0] t;
    t = (32'(n) << GRANULE_SHIFT) - 32'(HEADER_BYTES);
    return t[15:0];
  endfunction

  // block table: {free, length}; length zero marks a granule with no block start
  logic [LW:0] mem [HEAP_UNITS];
  logic [LW:0] rd_q;
  logic        we;
  logic [AW-1:0] wa, ra;
  logic [LW:0] wd;

  logic [HB_W-1:0]   heap_bytes_r;
  logic [LW-1:0]     units_r;
  logic [15:0]       free_tot_r, used_tot_r;
  logic [AW-1:0]     clr_addr_r;
  logic              op_r;
  logic [15:0]       req_r, off_r, offset_r;
  logic [NEED_W-1:0] need_r;
  logic [LW-1:0]     cur_r, prev_r, prev_len_r, fu_r, nx_r, len_r;
  logic              prev_free_r;
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [15:0]       out_off_r, out_free_r, out_used_r;

  logic              rfree;
  logic [LW-1:0]     rlen;
  logic [LW-1:0]     cur_step, fu_step, need_l, take_len;
  logic [17:0]       nsum;
  logic [NEED_W-1:0] ncalc, need_calc;
  logic [15:0]       ustart;
  logic [11:0]       u_full;
  logic [31:0]       diff, offs;

  assign rfree    = rd_q[LW];
  assign rlen     = rd_q[LW-1:0];
  assign cur_step = cur_r + rlen;
  assign fu_step  = fu_r + rlen;
  assign need_l   = LW'(need_r);
  assign diff     = 32'(rlen) - 32'(need_r);
  assign take_len = stat.split ? need_l : rlen;
  assign offs     = (32'(cur_r) << GRANULE_SHIFT) + 32'(HEADER_BYTES);

  assign nsum      = 18'(in_request_bytes) + 18'(HEADER_BYTES + 15);
  assign ncalc     = nsum[16:4];
  assign need_calc = (32'(ncalc) < 32'(MINU)) ? NEED_W'(MINU) : ncalc;

  assign ustart = off_r - 16'(HEADER_BYTES);
  assign u_full = ustart[15:4];

  always_comb begin
    stat.clr_done    = (clr_addr_r == AW'(HEAP_UNITS - 1));
    stat.is_free_op  = op_r;
    stat.req_zero    = (req_r == 16'd0);
    stat.walk_end    = (32'(cur_r) >= 32'(units_r)) || (rlen == '0);
    stat.fit         = rfree && (rlen != '0) && (32'(rlen) >= 32'(need_r));
    stat.split       = (diff >= 32'(MINU));
    stat.off_null    = (off_r == 16'd0);
    stat.off_bad     = (off_r < 16'(HEADER_BYTES)) || (ustart[3:0] != 4'd0) ||
                       (32'(u_full) >= 32'(units_r));
    stat.blk_absent  = (rlen == '0);
    stat.blk_free    = rfree;
    stat.next_merge  = (nx_r < units_r) && (rlen != '0) && rfree;
    stat.at_target   = (cur_r == fu_r);
    stat.target_zero = (fu_r == '0);
    stat.prev_free   = prev_free_r;
    stat.out_free    = !out_valid_r || !out_stall;
  end

  // memory port selection per command
  always_comb begin
    we = 1'b0;
    wa = clr_addr_r;
    wd = '0;
    ra = '0;
    case (cmd.op)
      CMD_CLR_STEP: begin
        we = 1'b1;
        wd = (clr_addr_r == '0) ? {1'b1, units_r} : '0;
      end
      CMD_WALK_START: ra = '0;
      CMD_WALK_STEP:  ra = cur_step[AW-1:0];
      CMD_A_TAKE: begin
        we = 1'b1;
        wa = cur_r[AW-1:0];
        wd = {1'b0, take_len};
      end
      CMD_A_SPLIT: begin
        we = 1'b1;
        wa = AW'(cur_r + need_l);
        wd = {1'b1, len_r - need_l};
      end
      CMD_F_READ: ra = AW'(u_full);
      CMD_F_TAKE: begin
        we = 1'b1;
        wa = fu_r[AW-1:0];
        wd = {1'b1, rlen};
        ra = fu_step[AW-1:0];
      end
      CMD_F_MERGE_NEXT: begin
        we = 1'b1;
        wa = fu_r[AW-1:0];
        wd = {1'b1, len_r + rlen};
      end
      CMD_F_CLR_NEXT: begin
        we = 1'b1;
        wa = nx_r[AW-1:0];
      end
      CMD_F_MERGE_PREV: begin
        we = 1'b1;
        wa = prev_r[AW-1:0];
        wd = {1'b1, prev_len_r + len_r};
      end
      CMD_F_CLR_U: begin
        we = 1'b1;
        wa = fu_r[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_bytes_r <= HEAP_BYTES_RESET;
      units_r      <= units_of(HEAP_BYTES_RESET);
      free_tot_r   <= pay(units_of(HEAP_BYTES_RESET));
      used_tot_r   <= 16'd0;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else if (cfg_wr) begin
      heap_bytes_r <= cfg_wdata;
      units_r      <= units_of(cfg_wdata);
      free_tot_r   <= pay(units_of(cfg_wdata));
      used_tot_r   <= 16'd0;
      clr_addr_r   <= '0;
    end else begin
      if (out_valid_r && !out_stall && (cmd.op != CMD_RESULT)) out_valid_r <= 1'b0;
      case (cmd.op)
        CMD_CLR_STEP: clr_addr_r <= clr_addr_r + 1'b1;
        CMD_A_TAKE: begin
          free_tot_r <= stat.split ? free_tot_r - bytes_of(need_l)
                                   : free_tot_r - pay(rlen);
          used_tot_r <= used_tot_r + pay(take_len);
        end
        CMD_F_TAKE: begin
          used_tot_r <= used_tot_r - pay(rlen);
          free_tot_r <= free_tot_r + pay(rlen);
        end
        CMD_F_MERGE_NEXT, CMD_F_MERGE_PREV:
          free_tot_r <= free_tot_r + 16'(HEADER_BYTES);
        CMD_RESULT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // walk and item registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        op_r     <= in_opcode;
        req_r    <= in_request_bytes;
        off_r    <= in_payload_offset;
        need_r   <= need_calc;
        offset_r <= 16'd0;
      end
      CMD_WALK_START: begin
        cur_r       <= '0;
        prev_free_r <= 1'b0;
      end
      CMD_WALK_STEP: begin
        prev_r      <= cur_r;
        prev_len_r  <= rlen;
        prev_free_r <= rfree;
        cur_r       <= cur_step;
      end
      CMD_A_TAKE: begin
        len_r    <= rlen;
        offset_r <= offs[15:0];
      end
      CMD_F_READ:       fu_r  <= LW'(u_full);
      CMD_F_TAKE: begin
        len_r <= rlen;
        nx_r  <= fu_step;
      end
      CMD_F_MERGE_NEXT: len_r <= len_r + rlen;
      CMD_RESULT: begin
        out_status_r <= cmd.st;
        out_off_r    <= (cmd.st == ST_OK) ? offset_r : 16'd0;
        out_free_r   <= free_tot_r;
        out_used_r   <= used_tot_r;
      end
      default: ;
    endcase
  end

  assign heap_bytes             = heap_bytes_r;
  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_result_offset      = out_off_r;
  assign out_free_payload_bytes = out_free_r;
  assign out_used_payload_bytes = out_used_r;

endmodule

`default_nettype wire

// ===== hdl/ffha_ctrl.sv =====
// Controller of the first-fit heap allocator: sequences clearing,
// allocate walks and free/merge steps. Depends on ffha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffha_ctrl
  import ffha_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire logic     cfg_wr,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_AWALK, S_ASPLIT, S_FGOT, S_FNEXT,
    S_FCLRNX, S_PSTART, S_PWALK, S_FCLRU, S_FINISH
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    cmd.op    = CMD_IDLE;
    cmd.st    = st_r;
    case (state_r)
      S_CLEAR: begin
        cmd.op = CMD_CLR_STEP;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = CMD_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!stat.is_free_op) begin
          if (stat.req_zero) begin
            st_nxt = ST_ZERO_SIZE; state_nxt = S_FINISH;
          end else begin
            cmd.op = CMD_WALK_START; state_nxt = S_AWALK;
          end
        end else if (stat.off_null) begin
          st_nxt = ST_NULL_FREE; state_nxt = S_FINISH;
        end else if (stat.off_bad) begin
          st_nxt = ST_BAD_ADDR; state_nxt = S_FINISH;
        end else begin
          cmd.op = CMD_F_READ; state_nxt = S_FGOT;
        end
      end
      S_AWALK: begin
        if (stat.walk_end) begin
          st_nxt = ST_NO_FIT; state_nxt = S_FINISH;
        end else if (stat.fit) begin
          cmd.op    = CMD_A_TAKE;
          st_nxt    = ST_OK;
          state_nxt = stat.split ? S_ASPLIT : S_FINISH;
        end else begin
          cmd.op = CMD_WALK_STEP;
        end
      end
      S_ASPLIT: begin
        cmd.op = CMD_A_SPLIT; state_nxt = S_FINISH;
      end
      S_FGOT: begin
        if (stat.blk_absent) begin
          st_nxt = ST_BAD_ADDR; state_nxt = S_FINISH;
        end else if (stat.blk_free) begin
          st_nxt = ST_DOUBLE_FREE; state_nxt = S_FINISH;
        end else begin
          cmd.op = CMD_F_TAKE; st_nxt = ST_OK; state_nxt = S_FNEXT;
        end
      end
      S_FNEXT: begin
        if (stat.next_merge) begin
          cmd.op = CMD_F_MERGE_NEXT; state_nxt = S_FCLRNX;
        end else begin
          state_nxt = S_PSTART;
        end
      end
      S_FCLRNX: begin
        cmd.op = CMD_F_CLR_NEXT; state_nxt = S_PSTART;
      end
      S_PSTART: begin
        if (stat.target_zero) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.op = CMD_WALK_START; state_nxt = S_PWALK;
        end
      end
      S_PWALK: begin
        if (stat.at_target) begin
          if (stat.prev_free) begin
            cmd.op = CMD_F_MERGE_PREV; state_nxt = S_FCLRU;
          end else begin
            state_nxt = S_FINISH;
          end
        end else if (stat.walk_end) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.op = CMD_WALK_STEP;
        end
      end
      S_FCLRU: begin
        cmd.op = CMD_F_CLR_U; state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.op = CMD_RESULT; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
    if (cfg_wr) begin
      cmd.op    = CMD_IDLE;
      state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator: APB register port, controller
// and datapath. Depends on ffha_pkg, ffha_ctrl and ffha_dp.
//
// The heap is a row of 16-byte granules split into blocks, each with a
// header of HEADER_BYTES. An allocate walks the blocks from granule zero,
// one block per clock, and takes the first free block that fits, splitting
// off the tail when enough is left. A free checks the offset, reads the
// block and its next neighbour, merges forward, then walks from granule
// zero to find the previous block (one block per clock) and merges
// backward. The walk rate is set by the single read port of the block
// table memory. One item is in work at a time; the result register lets the
// next item enter while a result still waits for its transfer. After reset
// and after every write to heap_bytes a clearing pass over every granule
// rebuilds the table as one free block; no item is taken during that pass.
// heap_bytes lies at byte address 0 of the register port.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HEAP_UNITS   = 4096,
  parameter int HEADER_BYTES = 24,
  parameter int MIN_BLOCK    = 40
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [15:0] in_request_bytes,
  input  wire logic [15:0] in_payload_offset,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [15:0]      out_result_offset,
  output logic [15:0]      out_free_payload_bytes,
  output logic [15:0]      out_used_payload_bytes,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  dp_cmd_t         cmd;
  dp_stat_t        stat;
  logic            cfg_wr;
  logic [HB_W-1:0] heap_bytes;

  // only the register at index zero exists; other addresses drop the write
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? 32'(heap_bytes) : 32'd0;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cfg_wr   (cfg_wr),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffha_dp #(
    .HEAP_UNITS   (HEAP_UNITS),
    .HEADER_BYTES (HEADER_BYTES),
    .MIN_BLOCK    (MIN_BLOCK)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .stat                   (stat),
    .in_opcode              (in_opcode),
    .in_request_bytes       (in_request_bytes),
    .in_payload_offset      (in_payload_offset),
    .cfg_wr                 (cfg_wr),
    .cfg_wdata              (pwdata[HB_W-1:0]),
    .heap_bytes             (heap_bytes),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_result_offset      (out_result_offset),
    .out_free_payload_bytes (out_free_payload_bytes),
    .out_used_payload_bytes (out_used_payload_bytes)
  );

endmodule

`default_nettype wire
